[design/deflate_match_window_copy_macros.svh]
// Assertion macros shared by the match window copy design.
`ifndef DEFLATE_MATCH_WINDOW_COPY_MACROS_SVH
`define DEFLATE_MATCH_WINDOW_COPY_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DMWC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/dmwc_pkg.sv]
// Package for the match window copy block: widths, codes and deflate tables.
package dmwc_pkg;

   localparam int WINDOW_BYTES_DEF     = 32768;
   localparam int BYTES_PER_RESULT_DEF = 8;

   // Field widths
   localparam int LIT_W    = 8;
   localparam int LCODE_W  = 9;
   localparam int LEXT_W   = 5;
   localparam int DCODE_W  = 5;
   localparam int DEXT_W   = 13;
   localparam int OUT_W    = 64;
   localparam int COUNT_W  = 4;
   localparam int LEN_W    = 9;
   localparam int DIST_W   = 16;
   localparam int LIDX_W   = 5;

   // Short-distance bypass buffer of the most recently written bytes
   localparam int RECENT_BYTES = 8;
   localparam int RECENT_IDX_W = 3;

   // Codes
   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_MATCH   = 1'b1;
   localparam int   LCODE_FIRST  = 257;
   localparam int   LCODE_LAST   = 285;
   localparam int   DCODE_LAST   = 29;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [DIST_W-1:0] dist_type;

   // Base length per length symbol minus 257
   function automatic len_type len_base_f(input logic [LIDX_W-1:0] idx);
      len_type r;
      unique case (idx)
         5'd0:  r = 9'd3;   5'd1:  r = 9'd4;   5'd2:  r = 9'd5;   5'd3:  r = 9'd6;
         5'd4:  r = 9'd7;   5'd5:  r = 9'd8;   5'd6:  r = 9'd9;   5'd7:  r = 9'd10;
         5'd8:  r = 9'd11;  5'd9:  r = 9'd13;  5'd10: r = 9'd15;  5'd11: r = 9'd17;
         5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
         5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
         5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
         5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
         5'd28: r = 9'd258;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Extra-bit count per length symbol minus 257
   function automatic logic [2:0] len_bits_f(input logic [LIDX_W-1:0] idx);
      logic [2:0] r;
      if (idx >= 5'd28)      r = 3'd0;
      else if (idx >= 5'd24) r = 3'd5;
      else if (idx >= 5'd20) r = 3'd4;
      else if (idx >= 5'd16) r = 3'd3;
      else if (idx >= 5'd12) r = 3'd2;
      else if (idx >= 5'd8)  r = 3'd1;
      else                   r = 3'd0;
      return r;
   endfunction

   // Base distance per distance symbol
   function automatic dist_type dist_base_f(input logic [DCODE_W-1:0] code);
      dist_type r;
      unique case (code)
         5'd0:  r = 16'd1;     5'd1:  r = 16'd2;     5'd2:  r = 16'd3;
         5'd3:  r = 16'd4;     5'd4:  r = 16'd5;     5'd5:  r = 16'd7;
         5'd6:  r = 16'd9;     5'd7:  r = 16'd13;    5'd8:  r = 16'd17;
         5'd9:  r = 16'd25;    5'd10: r = 16'd33;    5'd11: r = 16'd49;
         5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
         5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
         5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
         5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
         5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
         5'd27: r = 16'd12289; 5'd28: r = 16'd16385; 5'd29: r = 16'd24577;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Extra-bit count per distance symbol: two symbols per step from code 4
   function automatic logic [3:0] dist_bits_f(input logic [DCODE_W-1:0] code);
      logic [3:0] r;
      if (code < 5'd4) r = 4'd0;
      else             r = 4'(code[4:1] - 4'd1);
      return r;
   endfunction

endpackage

[design/dmwc_ifs.sv]
// Request and response channel interfaces of the match window copy block.
interface dmwc_req_if;
   import dmwc_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [LIT_W-1:0]   literal;
   logic [LCODE_W-1:0] length_code;
   logic [LEXT_W-1:0]  length_extra;
   logic [DCODE_W-1:0] distance_code;
   logic [DEXT_W-1:0]  distance_extra;

   modport source (output valid, kind, literal, length_code, length_extra,
                   distance_code, distance_extra, input ready);
   modport sink   (input valid, kind, literal, length_code, length_extra,
                   distance_code, distance_extra, output ready);
endinterface

interface dmwc_rsp_if;
   import dmwc_pkg::*;
   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   out_bytes;
   logic [COUNT_W-1:0] byte_count;
   logic               last;
   logic               error;

   modport source (output valid, out_bytes, byte_count, last, error, input ready);
   modport sink   (input valid, out_bytes, byte_count, last, error, output ready);
endinterface

[design/deflate_match_window_copy.sv]
// Deflate back end: literal and length/distance requests copied through a history window.
//
// Request channel req_ch takes one decoded item: a literal byte or a match
// (length symbol 257-285 with extra value, distance symbol 0-29 with extra value).
// Response channel rsp_ch returns the produced bytes, up to BYTES_PER_RESULT per
// response, first byte in the low bits; last marks the final response of a
// request, error marks a bad symbol or a distance beyond the written history.
// A literal answers in the cycle after acceptance; a rejected match
// answers after the CALC state, through the response register. A match
// of L bytes moves one byte per cycle through the single window RAM (one read,
// one write per cycle) while no full word waits for the response register; it
// starts after the CALC setup state, pauses behind each full response and ends with the drain of the last word.
// Only one request is in flight; req_ch.ready is low while a match is copied.
// Distances up to eight bytes are served from a small bypass of the last
// written bytes, so overlapping copies repeat correctly without RAM stalls.
// Reset clears the write pointer and fill count; the window RAM is not
// cleared, since no entry is read before it is written.
// When the receiver stalls the response register holds, one more full word
// waits behind it, and the copy pauses until space frees up.
module deflate_match_window_copy #(
   parameter int WINDOW_BYTES     = dmwc_pkg::WINDOW_BYTES_DEF,
   parameter int BYTES_PER_RESULT = dmwc_pkg::BYTES_PER_RESULT_DEF
) (
   input logic        clock,
   input logic        reset,
   dmwc_req_if.sink   req_ch,
   dmwc_rsp_if.source rsp_ch
);
   import dmwc_pkg::*;

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam int DW = AW + 1;
   localparam int FW = $clog2(WINDOW_BYTES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;

   // Window RAM
   logic [LIT_W-1:0] window_mem [WINDOW_BYTES];
   logic [LIT_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [LIT_W-1:0] mem_wdata;
   logic             rd_en;

   // Control and pointers
   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic             small_ff, small_in;
   logic [RECENT_IDX_W-1:0] dsel_ff, dsel_in;
   logic [LIT_W-1:0] recent_ff [RECENT_BYTES];
   logic [LIT_W-1:0] recent_in [RECENT_BYTES];

   // Latched match fields
   logic [LCODE_W-1:0] lcode_ff, lcode_in;
   logic [LEXT_W-1:0]  lext_ff, lext_in;
   logic [DCODE_W-1:0] dcode_ff, dcode_in;
   logic [DEXT_W-1:0]  dext_ff, dext_in;

   // Byte in resolve stage
   logic res_valid_ff, res_valid_in;
   logic res_last_ff, res_last_in;

   // Word assembly and the full word waiting for the response register
   logic [OUT_W-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic               pend_ff, pend_in;
   logic [OUT_W-1:0]   pend_bytes_ff, pend_bytes_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;
   logic               pend_last_ff, pend_last_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_bytes_ff, rsp_bytes_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   // Match decode
   logic [LIDX_W-1:0] lidx;
   logic [2:0]        lbits;
   logic [3:0]        dbits;
   logic [LEXT_W-1:0] lmask;
   logic [DEXT_W-1:0] dmask;
   len_type           length;
   dist_type          distance;
   logic              calc_err;
   logic [DW-1:0]     dist_short;
   logic [DW-1:0]     src_full;

   logic             req_ready;
   logic             req_acc;
   logic             out_free;
   logic             res_fills;
   logic             issue;
   logic [LIT_W-1:0] res_byte;

   // Length, distance and source address of the latched match
   always_comb begin
      lidx  = LIDX_W'(lcode_ff - LCODE_W'(LCODE_FIRST));
      lbits = len_bits_f(lidx);
      dbits = dist_bits_f(dcode_ff);
      lmask = LEXT_W'((6'd1 << lbits) - 6'd1);
      dmask = DEXT_W'((14'd1 << dbits) - 14'd1);
      length   = len_base_f(lidx) + LEN_W'(lext_ff & lmask);
      distance = dist_base_f(dcode_ff) + DIST_W'(dext_ff & dmask);
      calc_err = (lcode_ff < LCODE_W'(LCODE_FIRST)) || (lcode_ff > LCODE_W'(LCODE_LAST))
              || (dcode_ff > DCODE_W'(DCODE_LAST))
              || ({1'b0, distance} > 17'(fill_ff));
      dist_short = DW'(distance);
      if ({1'b0, wp_ff} >= dist_short) begin
         src_full = {1'b0, wp_ff} - dist_short;
      end else begin
         src_full = {1'b0, wp_ff} + DW'(WINDOW_BYTES) - dist_short;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = (state_ff == ST_IDLE) && !res_valid_ff && !pend_ff && out_free;
   assign req_acc   = req_ch.valid && req_ready;
   assign res_byte  = small_ff ? recent_ff[dsel_ff] : rd_data_ff;
   assign res_fills = res_last_ff || (n_ff == COUNT_W'(BYTES_PER_RESULT - 1));
   assign issue     = (state_ff == ST_COPY) && !pend_ff && !(res_valid_ff && res_fills);

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      small_in      = small_ff;
      dsel_in       = dsel_ff;
      recent_in     = recent_ff;
      lcode_in      = lcode_ff;
      lext_in       = lext_ff;
      dcode_in      = dcode_ff;
      dext_in       = dext_ff;
      word_in       = word_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      mem_we        = 1'b0;
      mem_wdata     = res_byte;
      rd_en         = 1'b0;

      // response taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.kind == KIND_LITERAL) begin
                  mem_we       = 1'b1;
                  mem_wdata    = req_ch.literal;
                  rsp_valid_in = 1'b1;
                  rsp_bytes_in = OUT_W'(req_ch.literal);
                  rsp_count_in = COUNT_W'(1);
                  rsp_last_in  = 1'b1;
                  rsp_err_in   = 1'b0;
               end else begin
                  lcode_in = req_ch.length_code;
                  lext_in  = req_ch.length_extra;
                  dcode_in = req_ch.distance_code;
                  dext_in  = req_ch.distance_extra;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (calc_err) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_bytes_in = '0;
                  rsp_count_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_err_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               remain_in  = length;
               rd_addr_in = src_full[AW-1:0];
               small_in   = (distance <= DIST_W'(RECENT_BYTES));
               dsel_in    = RECENT_IDX_W'(distance - DIST_W'(1));
               state_in   = ST_COPY;
            end
         end
         ST_COPY: begin
            if (issue) begin
               rd_en      = 1'b1;
               remain_in  = remain_ff - LEN_W'(1);
               rd_addr_in = (rd_addr_ff == AW'(WINDOW_BYTES - 1)) ? '0
                                                                   : rd_addr_ff + AW'(1);
               if (remain_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_valid_in = rd_en;
      res_last_in  = rd_en && (remain_ff == LEN_W'(1));

      // resolve: write the copied byte back and add it to the word
      if (res_valid_ff) begin
         mem_we = 1'b1;
         if (res_fills) begin
            pend_in       = 1'b1;
            pend_bytes_in = word_ff | (OUT_W'(res_byte) << {n_ff, 3'b000});
            pend_count_in = n_ff + COUNT_W'(1);
            pend_last_in  = res_last_ff;
            word_in       = '0;
            n_in          = '0;
         end else begin
            word_in = word_ff | (OUT_W'(res_byte) << {n_ff, 3'b000});
            n_in    = n_ff + COUNT_W'(1);
         end
      end

      // full word into the response register
      if (pend_ff && out_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_bytes_in = pend_bytes_ff;
         rsp_count_in = pend_count_ff;
         rsp_last_in  = pend_last_ff;
         rsp_err_in   = 1'b0;
      end

      // window bookkeeping on every byte written
      if (mem_we) begin
         wp_in = (wp_ff == AW'(WINDOW_BYTES - 1)) ? '0 : wp_ff + AW'(1);
         if (fill_ff != FW'(WINDOW_BYTES)) begin
            fill_in = fill_ff + FW'(1);
         end
         recent_in[0] = mem_wdata;
         for (int i = 1; i < RECENT_BYTES; i++) begin
            recent_in[i] = recent_ff[i-1];
         end
      end
   end

   // Window RAM: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[wp_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= window_mem[rd_addr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         res_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         word_ff      <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         res_valid_ff <= res_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         word_ff      <= word_in;
         n_ff         <= n_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      remain_ff     <= remain_in;
      small_ff      <= small_in;
      dsel_ff       <= dsel_in;
      recent_ff     <= recent_in;
      lcode_ff      <= lcode_in;
      lext_ff       <= lext_in;
      dcode_ff      <= dcode_in;
      dext_ff       <= dext_in;
      res_last_ff   <= res_last_in;
      pend_bytes_ff <= pend_bytes_in;
      pend_count_ff <= pend_count_in;
      pend_last_ff  <= pend_last_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_bytes  = rsp_bytes_ff;
   assign rsp_ch.byte_count = rsp_count_ff;
   assign rsp_ch.last       = rsp_last_ff;
   assign rsp_ch.error      = rsp_err_ff;

   // Checks
`include "deflate_match_window_copy_macros.svh"

   `DMWC_ASSERT_NOW(a_err_shape, rsp_valid_ff && rsp_err_ff,
      rsp_count_ff == '0 && rsp_last_ff && rsp_bytes_ff == '0, "error response malformed")
   `DMWC_ASSERT_NEXT(a_lit_resp, req_acc && req_ch.kind == KIND_LITERAL,
      rsp_valid_ff && rsp_count_ff == COUNT_W'(1) && rsp_last_ff && !rsp_err_ff,
      "literal request gave no single-byte response")
   `DMWC_ASSERT_NEXT(a_pend_hold, pend_ff && !out_free,
      pend_ff && $stable(pend_bytes_ff) && $stable(pend_count_ff), "waiting word lost")
   `DMWC_ASSERT_NOW(a_fill_max, 1'b1, fill_ff <= FW'(WINDOW_BYTES), "fill count overflow")

endmodule
